FILE: rtl/psi_pat_pmt_section_parser_defines.svh
// Assertion macros shared by the section parser RTL.
`ifndef PSI_PAT_PMT_SECTION_PARSER_DEFINES_SVH
`define PSI_PAT_PMT_SECTION_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PPSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("section parser: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("section parser: next-cycle check failed");

`endif

FILE: rtl/ppsp_pkg.sv
// Types and constants of the PSI section parser.
`timescale 1ns / 1ps

package ppsp_pkg;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_NETWORK = 2'd1,
      KIND_PROGRAM = 2'd2,
      KIND_ES      = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] section_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  table_code;
      logic [15:0] first_value;
      logic [12:0] pid;
      logic [11:0] info_length;
   } rsp_type;

   localparam logic [7:0]  TABLE_PAT      = 8'h00;
   localparam logic [7:0]  TABLE_PMT      = 8'h02;
   localparam logic [7:0]  MAX_ES_RESET   = 8'd20;
   localparam logic [7:0]  ES_COUNT_SAT   = 8'hFF;

   localparam logic [12:0] POS_TABLE_ID   = 13'd0;
   localparam logic [12:0] POS_LEN_HI     = 13'd1;
   localparam logic [12:0] POS_LEN_LO     = 13'd2;
   localparam logic [12:0] POS_PAT_LOOP   = 13'd8;
   localparam logic [12:0] POS_PI_HI      = 13'd10;
   localparam logic [12:0] POS_PI_LO      = 13'd11;
   localparam logic [12:0] POS_PMT_LOOP   = 13'd12;

   localparam logic [2:0]  PAT_ENTRY_LAST = 3'd3;
   localparam logic [2:0]  PMT_ENTRY_LAST = 3'd4;

endpackage

FILE: rtl/ppsp_if.sv
// Valid/ready channel interfaces of the PSI section parser.
`timescale 1ns / 1ps

interface ppsp_req_if;
   logic              valid;
   logic              ready;
   ppsp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ppsp_rsp_if;
   logic              valid;
   logic              ready;
   ppsp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ppsp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/psi_pat_pmt_section_parser.sv
// Top level of the PAT/PMT section parser: byte-wise parsing and result buffering.
//
// The req channel takes one section byte per transaction, with first_byte
// marking the table id that opens a section. The rsp channel gives the header,
// PAT entries and PMT elementary stream entries in section order. The csr
// channel writes the limit on reported elementary stream entries; it is always
// ready and should only be written while the block is idle.
// Each byte is parsed in a single registered pass, so one byte is taken every
// cycle while req ready is high, and its result, if any, is registered for rsp.
// Results leave through an output register backed by one skid entry, so bytes
// keep flowing while a result waits to be taken. When both hold a result and
// the receiver stalls, req ready drops until the output register drains.
// A synchronous reset sets the entry limit to 20, empties the result buffer
// and leaves no section open, so bytes are ignored until the next first_byte.
`timescale 1ns / 1ps
`include "psi_pat_pmt_section_parser_defines.svh"

module psi_pat_pmt_section_parser (
   input logic        clock,
   input logic        reset,
   ppsp_req_if.sink   req_chan,
   ppsp_rsp_if.source rsp_chan,
   ppsp_csr_if.sink   csr_chan
);

   logic        in_section_ff, in_section_in;
   logic [12:0] byte_position_ff, byte_position_in;
   logic [7:0]  current_table_ff, current_table_in;
   logic [11:0] section_len_ff, section_len_in;
   logic [3:0]  program_info_hi_ff, program_info_hi_in;
   logic [2:0]  entry_byte_index_ff, entry_byte_index_in;
   logic [31:0] entry_shift_ff, entry_shift_in;
   logic [11:0] descriptor_skip_ff, descriptor_skip_in;
   logic [7:0]  es_entry_count_ff, es_entry_count_in;
   logic [7:0]  max_es_entries_ff, max_es_entries_in;

   logic              out_valid_ff, out_valid_in;
   ppsp_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   ppsp_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              req_fire;
   logic              active;
   logic              start;
   logic [7:0]        b;
   logic [12:0]       p;
   logic              res_valid;
   ppsp_pkg::rsp_type res_data;
   logic [31:0]       pat_entry;
   logic [39:0]       pmt_entry;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign start    = req_chan.payload.first_byte;
   assign b        = req_chan.payload.section_byte;
   assign active   = start || in_section_ff;
   assign p        = start ? 13'd0 : byte_position_ff;

   assign pat_entry = {(start ? 24'd0 : entry_shift_ff[23:0]), b};
   assign pmt_entry = {(start ? 32'd0 : entry_shift_ff), b};

   always_comb begin
      in_section_in       = in_section_ff;
      byte_position_in    = byte_position_ff;
      current_table_in    = current_table_ff;
      section_len_in      = section_len_ff;
      program_info_hi_in  = program_info_hi_ff;
      entry_byte_index_in = entry_byte_index_ff;
      entry_shift_in      = entry_shift_ff;
      descriptor_skip_in  = descriptor_skip_ff;
      es_entry_count_in   = es_entry_count_ff;
      res_valid           = 1'b0;
      res_data            = '0;
      res_data.table_code = start ? 8'd0 : current_table_ff;

      if (req_fire && active) begin
         if (start) begin
            current_table_in    = 8'd0;
            section_len_in      = 12'd0;
            program_info_hi_in  = 4'd0;
            entry_byte_index_in = 3'd0;
            entry_shift_in      = 32'd0;
            descriptor_skip_in  = 12'd0;
            es_entry_count_in   = 8'd0;
         end

         if (p == ppsp_pkg::POS_TABLE_ID) begin
            current_table_in = b;
         end else if (p == ppsp_pkg::POS_LEN_HI) begin
            section_len_in = {b[3:0], 8'h00};
         end else if (p == ppsp_pkg::POS_LEN_LO) begin
            section_len_in       = {section_len_in[11:8], b};
            res_valid            = 1'b1;
            res_data.kind        = ppsp_pkg::KIND_HEADER;
            res_data.first_value = {4'd0, section_len_in};
         end else if (current_table_in == ppsp_pkg::TABLE_PAT) begin
            if (p >= ppsp_pkg::POS_PAT_LOOP &&
                ({1'b0, p} + 14'd2) <= {2'b00, section_len_in}) begin
               entry_shift_in = {entry_shift_in[23:0], b};
               if (entry_byte_index_in == ppsp_pkg::PAT_ENTRY_LAST) begin
                  entry_byte_index_in  = 3'd0;
                  res_valid            = 1'b1;
                  res_data.kind        = (pat_entry[31:16] == 16'd0) ?
                                         ppsp_pkg::KIND_NETWORK : ppsp_pkg::KIND_PROGRAM;
                  res_data.first_value = pat_entry[31:16];
                  res_data.pid         = {pat_entry[12:8], pat_entry[7:0]};
               end else begin
                  entry_byte_index_in = entry_byte_index_in + 3'd1;
               end
            end
         end else if (current_table_in == ppsp_pkg::TABLE_PMT) begin
            if (p == ppsp_pkg::POS_PI_HI) begin
               program_info_hi_in = b[3:0];
            end else if (p == ppsp_pkg::POS_PI_LO) begin
               descriptor_skip_in = {program_info_hi_in, b};
            end else if (p >= ppsp_pkg::POS_PMT_LOOP) begin
               if (descriptor_skip_in != 12'd0) begin
                  descriptor_skip_in = descriptor_skip_in - 12'd1;
               end else if (!(entry_byte_index_in == 3'd0 &&
                              ({1'b0, p} + 14'd1) >= {2'b00, section_len_in})) begin
                  entry_shift_in = pmt_entry[31:0];
                  if (entry_byte_index_in == ppsp_pkg::PMT_ENTRY_LAST) begin
                     entry_byte_index_in = 3'd0;
                     descriptor_skip_in  = {pmt_entry[11:8], pmt_entry[7:0]};
                     res_valid           = (es_entry_count_in < max_es_entries_ff);
                     if (es_entry_count_in != ppsp_pkg::ES_COUNT_SAT) begin
                        es_entry_count_in = es_entry_count_in + 8'd1;
                     end
                     res_data.kind        = ppsp_pkg::KIND_ES;
                     res_data.first_value = {8'd0, pmt_entry[39:32]};
                     res_data.pid         = {pmt_entry[28:24], pmt_entry[23:16]};
                     res_data.info_length = {pmt_entry[11:8], pmt_entry[7:0]};
                  end else begin
                     entry_byte_index_in = entry_byte_index_in + 3'd1;
                  end
               end
            end
         end

         if (p >= ppsp_pkg::POS_LEN_LO &&
             {1'b0, p} >= (14'd2 + {2'b00, section_len_in})) begin
            in_section_in    = 1'b0;
            byte_position_in = p;
         end else begin
            in_section_in    = 1'b1;
            byte_position_in = p + 13'd1;
         end
      end
   end

   always_comb begin
      max_es_entries_in = max_es_entries_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         max_es_entries_in = csr_chan.payload;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_fire && res_valid;
            out_data_in  = res_data;
         end
      end else if (req_fire && res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_section_ff       <= 1'b0;
         byte_position_ff    <= 13'd0;
         current_table_ff    <= 8'd0;
         section_len_ff      <= 12'd0;
         program_info_hi_ff  <= 4'd0;
         entry_byte_index_ff <= 3'd0;
         entry_shift_ff      <= 32'd0;
         descriptor_skip_ff  <= 12'd0;
         es_entry_count_ff   <= 8'd0;
         max_es_entries_ff   <= ppsp_pkg::MAX_ES_RESET;
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         in_section_ff       <= in_section_in;
         byte_position_ff    <= byte_position_in;
         current_table_ff    <= current_table_in;
         section_len_ff      <= section_len_in;
         program_info_hi_ff  <= program_info_hi_in;
         entry_byte_index_ff <= entry_byte_index_in;
         entry_shift_ff      <= entry_shift_in;
         descriptor_skip_ff  <= descriptor_skip_in;
         es_entry_count_ff   <= es_entry_count_in;
         max_es_entries_ff   <= max_es_entries_in;
         out_valid_ff        <= out_valid_in;
         skid_valid_ff       <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_chan.ready   = !skid_valid_ff;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;
   assign csr_chan.ready   = 1'b1;

   `PPSP_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `PPSP_ASSERT_NEXT(a_stalled_result_kept, clock, reset,
      req_fire && res_valid && out_valid_ff && !rsp_chan.ready, skid_valid_ff)
   `PPSP_ASSERT_SAME(a_entry_index_bound, clock, reset, 1'b1,
      entry_byte_index_ff <= ppsp_pkg::PMT_ENTRY_LAST)
   `PPSP_ASSERT_SAME(a_position_bound, clock, reset, in_section_ff,
      byte_position_ff <= 13'd4097)

endmodule
